[rtl/core/cbd_pkg.sv]
// Shared types and constants for the circular buffer deque.
`default_nettype none

package cbd_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int FUNC_W  = 3;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_READ       = 3'd4,
      FUNC_CLEAR      = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FRONT,
      S_BACK,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

[rtl/core/circular_buffer_deque.sv]
// Double-ended queue on a ring store: top level.
//
// Request channel (req_*): one operation per item - push front, push back,
// pop front, pop back, read at index, clear. Response channel (rsp_*): one
// result per item with ok flag, word read, front and back words and count.
// Both channels use valid/ready; an item moves when both are high.
//
// A new request is taken only after the result of the last one has left the
// sequencer, since the single read port of the ring store is shared: the
// indexed word, the front word and the back word are read one after another.
//
// Reset clears the pointers, so the deque comes up empty; stored words are
// not cleared. The result register holds its item while rsp_ready is low;
// the next request may be accepted meanwhile, and its result waits in the
// last sequencer step until the register is taken.
`default_nettype none

module circular_buffer_deque
   import cbd_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [FUNC_W-1:0]  req_func,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic [INDEX_W-1:0] req_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_ok,
   output logic      [VALUE_W-1:0] rsp_read_value,
   output logic      [VALUE_W-1:0] rsp_front_value,
   output logic      [VALUE_W-1:0] rsp_back_value,
   output logic      [COUNT_W-1:0] rsp_count
);

   localparam int AW = $clog2(DEPTH);

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic [AW-1:0]         mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   cbd_ring #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   cbd_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_count       (rsp_count),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

endmodule

`default_nettype wire

[rtl/core/cbd_ring.sv]
// Ring storage: one write port and one read port with registered read data.
`default_nettype none

module cbd_ring
   import cbd_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]    wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/cbd_ctrl.sv]
// Pointer logic, operation sequencer and result register of the deque.
`default_nettype none

module cbd_ctrl
   import cbd_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [FUNC_W-1:0]        req_func,
   input  wire logic [VALUE_W-1:0]       req_value,
   input  wire logic [INDEX_W-1:0]       req_index,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_ok,
   output logic      [VALUE_W-1:0]       rsp_read_value,
   output logic      [VALUE_W-1:0]       rsp_front_value,
   output logic      [VALUE_W-1:0]       rsp_back_value,
   output logic      [COUNT_W-1:0]       rsp_count,
   output logic                          mem_wr_en,
   output logic      [$clog2(DEPTH)-1:0] mem_wr_addr,
   output logic      [DATA_WIDTH-1:0]    mem_wr_data,
   output logic      [$clog2(DEPTH)-1:0] mem_rd_addr,
   input  wire logic [DATA_WIDTH-1:0]    mem_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int SW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
   localparam logic [AW-1:0] LAST_P   = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_P  = (AW + 1)'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == LAST_P) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? LAST_P : p - 1'b1;
   endfunction

   function automatic logic [AW-1:0] ring_cnt(input logic [AW-1:0] h, input logic [AW-1:0] t);
      logic [AW:0] diff;
      diff = {1'b0, t} - {1'b0, h};
      if (t < h) begin
         diff = diff + DEPTH_P;
      end
      return diff[AW-1:0];
   endfunction

   function automatic logic [SW-1:0] wrap_sum(input logic [AW-1:0] h,
                                              input logic [INDEX_W-1:0] i);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(i);
      for (int k = 0; k < 8; k++) begin
         if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
         end
      end
      return s;
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic               ok_ff, ok_in;
   logic               is_read_ff, is_read_in;
   logic [VALUE_W-1:0] read_ff, read_in;
   logic [VALUE_W-1:0] front_ff, front_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [VALUE_W-1:0] rsp_read_ff, rsp_read_in;
   logic [VALUE_W-1:0] rsp_front_ff, rsp_front_in;
   logic [VALUE_W-1:0] rsp_back_ff, rsp_back_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [AW-1:0] count_now;
   logic [SW-1:0] idx_sum;
   logic [AW-1:0] idx_addr;
   logic [AW-1:0] back_addr;
   logic          full;
   logic          empty;
   logic          idx_lt;

   assign count_now = ring_cnt(head_ff, tail_ff);
   assign idx_sum   = wrap_sum(head_ff, req_index);
   assign idx_addr  = idx_sum[AW-1:0];
   assign back_addr = ptr_dec(tail_ff);
   assign full      = (count_now == LAST_P);
   assign empty     = (head_ff == tail_ff);
   assign idx_lt    = (SW'(req_index) < SW'(count_now));

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ok_in        = ok_ff;
      is_read_in   = is_read_ff;
      read_in      = read_ff;
      front_in     = front_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_read_in  = rsp_read_ff;
      rsp_front_in = rsp_front_ff;
      rsp_back_in  = rsp_back_ff;
      rsp_count_in = rsp_count_ff;
      req_ready    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = tail_ff;
      mem_wr_data  = DATA_WIDTH'(req_value);
      mem_rd_addr  = idx_addr;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready   = !reset;
            mem_rd_addr = idx_addr;
            if (req_valid && !reset) begin
               state_in   = S_FRONT;
               ok_in      = 1'b0;
               is_read_in = 1'b0;
               unique case (func_type'(req_func))
                  FUNC_PUSH_FRONT: begin
                     if (!full) begin
                        head_in     = ptr_dec(head_ff);
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = ptr_dec(head_ff);
                        ok_in       = 1'b1;
                     end
                  end
                  FUNC_PUSH_BACK: begin
                     if (!full) begin
                        tail_in     = ptr_inc(tail_ff);
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = tail_ff;
                        ok_in       = 1'b1;
                     end
                  end
                  FUNC_POP_FRONT: begin
                     if (!empty) begin
                        head_in = ptr_inc(head_ff);
                        ok_in   = 1'b1;
                     end
                  end
                  FUNC_POP_BACK: begin
                     if (!empty) begin
                        tail_in = ptr_dec(tail_ff);
                        ok_in   = 1'b1;
                     end
                  end
                  FUNC_READ: begin
                     is_read_in = 1'b1;
                     ok_in      = idx_lt;
                  end
                  FUNC_CLEAR: begin
                     head_in = '0;
                     tail_in = '0;
                     ok_in   = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         S_FRONT: begin
            mem_rd_addr = head_ff;
            read_in     = is_read_ff ? VALUE_W'(mem_rd_data) : '0;
            state_in    = S_BACK;
         end
         S_BACK: begin
            mem_rd_addr = back_addr;
            front_in    = VALUE_W'(mem_rd_data);
            state_in    = S_DONE;
         end
         S_DONE: begin
            mem_rd_addr = back_addr;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_read_in  = read_ff;
               rsp_front_in = front_ff;
               rsp_back_in  = VALUE_W'(mem_rd_data);
               rsp_count_in = COUNT_W'(count_now);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff        <= ok_in;
      is_read_ff   <= is_read_in;
      read_ff      <= read_in;
      front_ff     <= front_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_read_ff  <= rsp_read_in;
      rsp_front_ff <= rsp_front_in;
      rsp_back_ff  <= rsp_back_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_count       = rsp_count_ff;

endmodule

`default_nettype wire

[rtl/core/cbd_checker.sv]
// Port-level checks for the circular buffer deque, bound to the top level.
`default_nettype none

module cbd_checker
   import cbd_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [FUNC_W-1:0]  req_func,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_ok,
   input wire logic [VALUE_W-1:0] rsp_read_value,
   input wire logic [VALUE_W-1:0] rsp_front_value,
   input wire logic [VALUE_W-1:0] rsp_back_value,
   input wire logic [COUNT_W-1:0] rsp_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_read_value)
         && $stable(rsp_front_value) && $stable(rsp_back_value) && $stable(rsp_count))
      else $error("result item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in progress");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 4))
      else $error("result item without a matching request item");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && $past(req_func == FUNC_CLEAR, 4) |-> rsp_ok && (rsp_count == '0))
      else $error("clear did not empty the deque");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 16) || (int'(rsp_count) <= DEPTH - 1))
      else $error("count beyond capacity");

endmodule

bind circular_buffer_deque cbd_checker #(.DEPTH(DEPTH)) u_cbd_checker (.*);

`default_nettype wire

[sim/tb_circular_buffer_deque.sv]
// Testbench for circular_buffer_deque: directed table and random deque operations checked against a predictor.
module tb_circular_buffer_deque;
   import cbd_pkg::*;

   localparam int RING_SLOTS   = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1900;
   localparam int PHASE_ITEMS  = 64;
   localparam int MAX_GAP      = 18;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_CYCLES  = 250;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [FUNC_W-1:0] FUNC_RSVD_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_RSVD_HI = 3'd7;

   typedef struct packed {
      logic               ok;
      logic [VALUE_W-1:0] read_value;
      logic [VALUE_W-1:0] front_value;
      logic [VALUE_W-1:0] back_value;
      logic [COUNT_W-1:0] count;
   } deque_view_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic               typed;
      deque_view_type     view;
   } deque_op_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid;
   logic               req_ready;
   logic [FUNC_W-1:0]  req_func;
   logic [VALUE_W-1:0] req_value;
   logic [INDEX_W-1:0] req_index;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_ok;
   logic [VALUE_W-1:0] rsp_read_value;
   logic [VALUE_W-1:0] rsp_front_value;
   logic [VALUE_W-1:0] rsp_back_value;
   logic [COUNT_W-1:0] rsp_count;

   logic [VALUE_W-1:0] ring [RING_SLOTS];
   logic [INDEX_W-1:0] ring_head = '0;
   logic [INDEX_W-1:0] ring_tail = '0;

   deque_op_type   directed_ops [$];
   deque_view_type expected_views [$];

   int error_count   = 0;
   int results_taken = 0;
   int idle_cycles   = 0;
   bit calm          = 1'b0;

   circular_buffer_deque u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_count       (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic deque_view_type deque_apply(input logic [FUNC_W-1:0] op,
                                                  input logic [VALUE_W-1:0] word,
                                                  input logic [INDEX_W-1:0] pos);
      deque_view_type     view;
      logic [INDEX_W-1:0] used;
      logic [INDEX_W-1:0] slot;
      view = '0;
      used = ring_tail - ring_head;
      case (op)
         FUNC_PUSH_FRONT: if (used != RING_SLOTS - 1) begin
            ring_head       = ring_head - 1'b1;
            ring[ring_head] = word;
            view.ok         = 1'b1;
         end
         FUNC_PUSH_BACK: if (used != RING_SLOTS - 1) begin
            ring[ring_tail] = word;
            ring_tail       = ring_tail + 1'b1;
            view.ok         = 1'b1;
         end
         FUNC_POP_FRONT: if (used != 0) begin
            ring_head = ring_head + 1'b1;
            view.ok   = 1'b1;
         end
         FUNC_POP_BACK: if (used != 0) begin
            ring_tail = ring_tail - 1'b1;
            view.ok   = 1'b1;
         end
         FUNC_READ: begin
            slot            = ring_head + pos;
            view.read_value = ring[slot];
            view.ok         = (pos < used);
         end
         FUNC_CLEAR: begin
            ring_head = '0;
            ring_tail = '0;
            view.ok   = 1'b1;
         end
         default: ;
      endcase
      slot             = ring_tail - 1'b1;
      view.front_value = ring[ring_head];
      view.back_value  = ring[slot];
      view.count       = ring_tail - ring_head;
      return view;
   endfunction

   function automatic void add_row(input logic [FUNC_W-1:0] op,
                                   input logic [VALUE_W-1:0] word,
                                   input logic [INDEX_W-1:0] pos,
                                   input logic typed,
                                   input deque_view_type view);
      deque_op_type row;
      row.func  = op;
      row.value = word;
      row.index = pos;
      row.typed = typed;
      row.view  = view;
      directed_ops.push_back(row);
   endfunction

   function automatic deque_op_type random_op(input int mix);
      deque_op_type row;
      int roll;
      int push_pct;
      row      = '0;
      roll     = $urandom_range(0, 99);
      push_pct = (mix == 0) ? 75 : (mix == 1) ? 25 : 50;
      if (roll < 2) begin
         row.func = $urandom_range(0, 1) ? FUNC_RSVD_HI : FUNC_RSVD_LO;
      end else if (roll < 5) begin
         row.func = FUNC_CLEAR;
      end else if (roll < 20) begin
         row.func = FUNC_READ;
      end else if ($urandom_range(0, 99) < push_pct) begin
         row.func = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      end else begin
         row.func = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
      end
      case ($urandom_range(0, 7))
         0: row.value = '0;
         1: row.value = '1;
         default: row.value = $urandom;
      endcase
      row.index = INDEX_W'($urandom_range(0, RING_SLOTS - 1));
      return row;
   endfunction

   task automatic offer_item(input deque_op_type row);
      int             gap;
      deque_view_type predicted;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= row.func;
      req_value <= row.value;
      req_index <= row.index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = deque_apply(row.func, row.value, row.index);
      expected_views.push_back(row.typed ? row.view : predicted);
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(negedge clock);
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("circular_buffer_deque regression: fail");
      $finish;
   end

   initial begin
      int             stall;
      deque_view_type want;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         stall = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (results_taken == HOLD_AT) begin
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_taken++;
         if (expected_views.size() == 0) begin
            $error("rsp item with no request pending");
            error_count++;
         end else begin
            want = expected_views.pop_front();
            if (rsp_ok !== want.ok) begin
               $error("rsp_ok: expected %0d, got %0d", want.ok, rsp_ok);
               error_count++;
            end
            if (rsp_read_value !== want.read_value) begin
               $error("rsp_read_value: expected %h, got %h", want.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_front_value !== want.front_value) begin
               $error("rsp_front_value: expected %h, got %h", want.front_value, rsp_front_value);
               error_count++;
            end
            if (rsp_back_value !== want.back_value) begin
               $error("rsp_back_value: expected %h, got %h", want.back_value, rsp_back_value);
               error_count++;
            end
            if (rsp_count !== want.count) begin
               $error("rsp_count: expected %0d, got %0d", want.count, rsp_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      int k;
      int mix;
      req_valid = 1'b0;
      req_func  = '0;
      req_value = '0;
      req_index = '0;

      // fill the deque to capacity, then walk full, out-of-range, unused code and empty cases
      add_row(FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0, 1'b1,
              {1'b1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1});
      for (k = 0; k < RING_SLOTS - 2; k++) begin
         add_row(FUNC_PUSH_BACK, 32'h1111_1111 * (k + 1), 4'd0, 1'b0, '0);
      end
      add_row(FUNC_PUSH_BACK, 32'h1234_5678, 4'd0, 1'b1,
              {1'b0, 32'h0, 32'hFFFF_FFFF, 32'hEEEE_EEEE, 4'd15});
      add_row(FUNC_POP_FRONT, 32'h0, 4'd0, 1'b0, '0);
      add_row(FUNC_PUSH_BACK, 32'h0, 4'd0, 1'b0, '0);
      add_row(FUNC_READ, 32'h0, 4'd14, 1'b0, '0);
      add_row(FUNC_READ, 32'h0, 4'd15, 1'b1,
              {1'b0, 32'hFFFF_FFFF, 32'h1111_1111, 32'h0, 4'd15});
      add_row(FUNC_RSVD_LO, 32'hA5A5_A5A5, 4'd3, 1'b1,
              {1'b0, 32'h0, 32'h1111_1111, 32'h0, 4'd15});
      add_row(FUNC_POP_BACK, 32'h0, 4'd0, 1'b0, '0);
      add_row(FUNC_CLEAR, 32'h0, 4'd0, 1'b1,
              {1'b1, 32'h0, 32'h1111_1111, 32'hFFFF_FFFF, 4'd0});
      add_row(FUNC_POP_FRONT, 32'h0, 4'd0, 1'b1,
              {1'b0, 32'h0, 32'h1111_1111, 32'hFFFF_FFFF, 4'd0});
      add_row(FUNC_POP_BACK, 32'h0, 4'd0, 1'b1,
              {1'b0, 32'h0, 32'h1111_1111, 32'hFFFF_FFFF, 4'd0});
      add_row(FUNC_READ, 32'h0, 4'd0, 1'b0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_ops[i]) begin
         offer_item(directed_ops[i]);
      end

      mix = 2;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % PHASE_ITEMS == 0) begin
            mix  = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
         end
         offer_item(random_op(mix));
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("circular_buffer_deque regression: pass");
      end else begin
         $display("circular_buffer_deque regression: fail");
      end
      $finish;
   end

endmodule
